>>> hdl/arp_cache_with_pending_timeouts_assert.svh
// Assertion macros shared by the address-resolution cache modules.
`ifndef ARP_CACHE_WITH_PENDING_TIMEOUTS_ASSERT_SVH
`define ARP_CACHE_WITH_PENDING_TIMEOUTS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define ARPC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ARPC_ASSERT(lbl, prop, msg)
`define ARPC_NEVER(lbl, cond, msg)
`endif
`endif

>>> hdl/arpc_pkg.sv
// Types and constants shared by the address-resolution cache modules.
package arpc_pkg;

  // Operation codes of an input transaction.
  typedef enum logic [2:0] {
    OP_LOOKUP  = 3'd0,
    OP_REPLY   = 3'd1,
    OP_REQUEST = 3'd2,
    OP_QUERY   = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  // Result kinds.
  localparam logic [2:0] KIND_LOOKUP   = 3'd0;
  localparam logic [2:0] KIND_RESOLVED = 3'd1;
  localparam logic [2:0] KIND_PENDING  = 3'd2;
  localparam logic [2:0] KIND_RESEND   = 3'd3;
  localparam logic [2:0] KIND_MARK     = 3'd4;

  // A tick serves at most this many due entries.
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int unsigned DELAY_W          = 8;
  localparam logic [DELAY_W-1:0] DELAY_RST = 8'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] ip_addr;
    logic [47:0] hw_addr;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] ip_out;
    logic [47:0] hw_out;
    logic        found;
    logic        last;
  } res_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e         op;
    logic [31:0] ip;
    logic [47:0] hw;
    logic [31:0] now;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_P_RD,
    BK_P_CHK,
    BK_C_RD,
    BK_C_CHK,
    BK_EMIT
  } bk_state_e;

endpackage

>>> hdl/arp_cache_with_pending_timeouts.sv
// Top level of the address-resolution cache with pending-request timeouts.
//
//   Channel   Handshake               Payload      Direction
//   input     push / full             in_item_i    in
//   result    empty / pop             res_o        out
//   config    cfg_valid_i/cfg_ready_o cfg_data_i   in
//
// Each table entry visited takes a read state and a check state at the registered RAM read port.
// Reset clears all valid bits at once; the delay register resets to 5. No clearing pass.
// A full result queue stalls the back end; the input queue keeps accepting until full.
module arp_cache_with_pending_timeouts #(
  parameter int unsigned CACHE_ENTRIES   = 16,
  parameter int unsigned PENDING_ENTRIES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  arpc_pkg::in_item_t           in_item_i,
  output logic                         empty,
  input  logic                         pop,
  output arpc_pkg::res_t               res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [arpc_pkg::DELAY_W-1:0] cfg_data_i
);
  import arpc_pkg::*;

  logic [DELAY_W-1:0] resend_delay_q;
  cmd_t               cmd;
  logic               cmd_valid, cmd_pop;
  res_t               res_push_data;
  logic               res_push, res_full;
  logic [$bits(res_t)-1:0] res_rdata;

  // Delay register, written by a configuration transaction.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resend_delay_q <= DELAY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      resend_delay_q <= cfg_data_i;
    end
  end

  arpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  arpc_back #(
    .CACHE_ENTRIES   (CACHE_ENTRIES),
    .PENDING_ENTRIES (PENDING_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cmd_valid_i    (cmd_valid),
    .cmd_pop_o      (cmd_pop),
    .resend_delay_i (resend_delay_q),
    .res_o          (res_push_data),
    .res_push_o     (res_push),
    .res_full_i     (res_full)
  );

  // Result queue between the back end and the result port.
  arpc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_push_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rdata),
    .empty_o (empty)
  );

  assign res_o = res_t'(res_rdata);

endmodule

>>> hdl/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/arpc_fifo.sv
// Small register queue carrying one packed word per transaction.
module arpc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/arpc_front.sv
// Front end: accepts input transactions, classifies the opcode and queues commands.
module arpc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  arpc_pkg::in_item_t item_i,
  output logic               full_o,
  output arpc_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i
);
  import arpc_pkg::*;

  logic  op_known;
  logic  q_empty;
  cmd_t  cmd_in;
  logic [$bits(cmd_t)-1:0] q_rdata;

  // Undefined opcodes are accepted and dropped here; they never reach the back.
  always_comb begin
    op_known = item_i.opcode inside {OP_LOOKUP, OP_REPLY, OP_REQUEST, OP_QUERY, OP_TICK};
  end

  // Build the command word from the input fields.
  always_comb begin
    cmd_in.op  = op_e'(item_i.opcode);
    cmd_in.ip  = item_i.ip_addr;
    cmd_in.hw  = item_i.hw_addr;
    cmd_in.now = item_i.now;
  end

  arpc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && op_known),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign cmd_o       = cmd_t'(q_rdata);
  assign cmd_valid_o = !q_empty;

endmodule

>>> hdl/arpc_back.sv
// Back end: executes commands against the cache and pending tables.
`include "arp_cache_with_pending_timeouts_assert.svh"
module arpc_back #(
  parameter int unsigned CACHE_ENTRIES   = 16,
  parameter int unsigned PENDING_ENTRIES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  arpc_pkg::cmd_t                 cmd_i,
  input  logic                           cmd_valid_i,
  output logic                           cmd_pop_o,
  input  logic [arpc_pkg::DELAY_W-1:0]   resend_delay_i,
  output arpc_pkg::res_t                 res_o,
  output logic                           res_push_o,
  input  logic                           res_full_i
);
  import arpc_pkg::*;

  localparam int unsigned CAW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned PAW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int unsigned CRW = 32 + 48;
  localparam int unsigned PRW = 32 + 32;

  bk_state_e state_q, state_d;
  cmd_t      cmd_q, cmd_d;
  res_t      res_q, res_d;
  logic [PAW-1:0] pidx_q, pidx_d, pfree_q, pfree_d;
  logic [CAW-1:0] cidx_q, cidx_d, cfree_q, cfree_d, victim_q, victim_d;
  logic           pfree_v_q, pfree_v_d, cfree_v_q, cfree_v_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CACHE_ENTRIES-1:0]   cache_valid_q, cache_valid_d;
  logic [PENDING_ENTRIES-1:0] pend_valid_q, pend_valid_d;

  logic           pram_we, cram_we;
  logic [PAW-1:0] pram_waddr;
  logic [CAW-1:0] cram_waddr;
  logic [PRW-1:0] pram_wdata, pram_rdata;
  logic [CRW-1:0] cram_wdata, cram_rdata;

  logic [31:0] p_ip, p_dl, c_ip, deadline;
  logic [47:0] c_hw;
  logic        p_hit, p_due, p_last, c_hit, c_last, tick_stall;

  function automatic res_t mk_res(logic [2:0] kind, logic [31:0] ip, logic [47:0] hw,
                                  logic fnd, logic lst);
    res_t r;
    r.result_kind = kind;
    r.ip_out      = ip;
    r.hw_out      = hw;
    r.found       = fnd;
    r.last        = lst;
    return r;
  endfunction

  // Pending table storage: protocol address over deadline.
  arpc_ram #(
    .WIDTH (PRW),
    .DEPTH (PENDING_ENTRIES)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .waddr_i (pram_waddr),
    .wdata_i (pram_wdata),
    .raddr_i (pidx_q),
    .rdata_o (pram_rdata)
  );

  // Cache storage: protocol address over hardware address.
  arpc_ram #(
    .WIDTH (CRW),
    .DEPTH (CACHE_ENTRIES)
  ) u_cache_ram (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .waddr_i (cram_waddr),
    .wdata_i (cram_wdata),
    .raddr_i (cidx_q),
    .rdata_o (cram_rdata)
  );

  // Compare the entry read in the previous cycle.
  assign p_ip     = pram_rdata[PRW-1:32];
  assign p_dl     = pram_rdata[31:0];
  assign c_ip     = cram_rdata[CRW-1:48];
  assign c_hw     = cram_rdata[47:0];
  assign deadline = cmd_q.now + 32'(resend_delay_i);
  assign p_hit    = pend_valid_q[pidx_q] && (p_ip == cmd_q.ip);
  assign p_due    = pend_valid_q[pidx_q] && (cmd_q.now > p_dl);
  assign p_last   = (pidx_q == PAW'(PENDING_ENTRIES - 1));
  assign c_hit    = cache_valid_q[cidx_q] && (c_ip == cmd_q.ip);
  assign c_last   = (cidx_q == CAW'(CACHE_ENTRIES - 1));
  // A held resend waits while the result queue is full.
  assign tick_stall = p_due && (n_q != '0) && res_full_i;

  assign res_o = res_q;

  // Sequencer: next state, table updates and result pushes.
  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    res_d         = res_q;
    pidx_d        = pidx_q;
    pfree_d       = pfree_q;
    pfree_v_d     = pfree_v_q;
    cidx_d        = cidx_q;
    cfree_d       = cfree_q;
    cfree_v_d     = cfree_v_q;
    victim_d      = victim_q;
    n_d           = n_q;
    cache_valid_d = cache_valid_q;
    pend_valid_d  = pend_valid_q;
    pram_we       = 1'b0;
    pram_waddr    = pidx_q;
    pram_wdata    = {cmd_q.ip, deadline};
    cram_we       = 1'b0;
    cram_waddr    = cidx_q;
    cram_wdata    = {cmd_q.ip, cmd_q.hw};
    cmd_pop_o     = 1'b0;
    res_push_o    = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          pidx_d    = '0;
          cidx_d    = '0;
          pfree_v_d = 1'b0;
          cfree_v_d = 1'b0;
          n_d       = '0;
          state_d   = (cmd_i.op == OP_LOOKUP) ? BK_C_RD : BK_P_RD;
        end
      end

      BK_P_RD: state_d = BK_P_CHK;

      BK_P_CHK: begin
        case (cmd_q.op)
          OP_QUERY: begin
            if (p_hit || p_last) begin
              res_d   = mk_res(KIND_PENDING, cmd_q.ip, '0, p_hit, 1'b1);
              state_d = BK_EMIT;
            end else begin
              pidx_d  = pidx_q + 1'b1;
              state_d = BK_P_RD;
            end
          end
          OP_REPLY: begin
            if (p_hit) begin
              pend_valid_d[pidx_q] = 1'b0;
              state_d              = BK_C_RD;
            end else if (p_last) begin
              state_d = BK_IDLE;
            end else begin
              pidx_d  = pidx_q + 1'b1;
              state_d = BK_P_RD;
            end
          end
          OP_REQUEST: begin
            if (p_hit) begin
              // Refresh the deadline of an address already pending.
              pram_we              = 1'b1;
              pend_valid_d[pidx_q] = 1'b1;
              res_d                = mk_res(KIND_MARK, cmd_q.ip, '0, 1'b1, 1'b1);
              state_d              = BK_EMIT;
            end else begin
              if (!pfree_v_q && !pend_valid_q[pidx_q]) begin
                pfree_v_d = 1'b1;
                pfree_d   = pidx_q;
              end
              if (p_last) begin
                // No match anywhere: take the lowest free entry, or drop.
                if (pfree_v_d) begin
                  pram_we               = 1'b1;
                  pram_waddr            = pfree_d;
                  pend_valid_d[pfree_d] = 1'b1;
                end
                res_d   = mk_res(KIND_MARK, cmd_q.ip, '0, pfree_v_d, 1'b1);
                state_d = BK_EMIT;
              end else begin
                pidx_d  = pidx_q + 1'b1;
                state_d = BK_P_RD;
              end
            end
          end
          OP_TICK: begin
            if (!tick_stall) begin
              if (p_due) begin
                // Re-arm the entry and hold its resend until the next one is known.
                pram_we    = 1'b1;
                pram_wdata = {p_ip, deadline};
                res_push_o = (n_q != '0);
                res_d      = mk_res(KIND_RESEND, p_ip, '0, 1'b0, 1'b0);
                n_d        = n_q + 1'b1;
              end
              if (p_last || (n_d == CNT_W'(MAX_RESULTS))) begin
                if (n_d != '0) begin
                  res_d.last = 1'b1;
                  state_d    = BK_EMIT;
                end else begin
                  state_d = BK_IDLE;
                end
              end else begin
                pidx_d  = pidx_q + 1'b1;
                state_d = BK_P_RD;
              end
            end
          end
          default: state_d = BK_IDLE;
        endcase
      end

      BK_C_RD: state_d = BK_C_CHK;

      BK_C_CHK: begin
        case (cmd_q.op)
          OP_LOOKUP: begin
            if (c_hit || c_last) begin
              res_d   = mk_res(KIND_LOOKUP, cmd_q.ip, c_hit ? c_hw : '0, c_hit, 1'b1);
              state_d = BK_EMIT;
            end else begin
              cidx_d  = cidx_q + 1'b1;
              state_d = BK_C_RD;
            end
          end
          OP_REPLY: begin
            if (c_hit) begin
              cram_we               = 1'b1;
              cache_valid_d[cidx_q] = 1'b1;
              res_d   = mk_res(KIND_RESOLVED, cmd_q.ip, cmd_q.hw, 1'b1, 1'b1);
              state_d = BK_EMIT;
            end else begin
              if (!cfree_v_q && !cache_valid_q[cidx_q]) begin
                cfree_v_d = 1'b1;
                cfree_d   = cidx_q;
              end
              if (c_last) begin
                // Lowest free entry, else round-robin replacement.
                cram_we = 1'b1;
                if (cfree_v_d) begin
                  cram_waddr = cfree_d;
                end else begin
                  cram_waddr = victim_q;
                  victim_d   = (victim_q == CAW'(CACHE_ENTRIES - 1)) ? '0
                                                                   : victim_q + 1'b1;
                end
                cache_valid_d[cram_waddr] = 1'b1;
                res_d   = mk_res(KIND_RESOLVED, cmd_q.ip, cmd_q.hw, 1'b1, 1'b1);
                state_d = BK_EMIT;
              end else begin
                cidx_d  = cidx_q + 1'b1;
                state_d = BK_C_RD;
              end
            end
          end
          default: state_d = BK_IDLE;
        endcase
      end

      BK_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end

      default: state_d = BK_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BK_IDLE;
      pidx_q        <= '0;
      cidx_q        <= '0;
      pfree_v_q     <= 1'b0;
      cfree_v_q     <= 1'b0;
      victim_q      <= '0;
      n_q           <= '0;
      cache_valid_q <= '0;
      pend_valid_q  <= '0;
    end else begin
      state_q       <= state_d;
      pidx_q        <= pidx_d;
      cidx_q        <= cidx_d;
      pfree_v_q     <= pfree_v_d;
      cfree_v_q     <= cfree_v_d;
      victim_q      <= victim_d;
      n_q           <= n_d;
      cache_valid_q <= cache_valid_d;
      pend_valid_q  <= pend_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    res_q   <= res_d;
    pfree_q <= pfree_d;
    cfree_q <= cfree_d;
  end

  // A result is never pushed into a full result queue.
  `ARPC_NEVER(a_push_full, res_push_o && res_full_i, "result pushed while queue full")
  // Tables are only written while a command is in progress.
  `ARPC_NEVER(a_idle_write, (state_q == BK_IDLE) && (pram_we || cram_we), "write while idle")
  // A tick never serves more entries than the result limit.
  `ARPC_ASSERT(a_tick_cap, n_q <= CNT_W'(MAX_RESULTS), "tick result count over limit")
  // Cache entries are never invalidated once written.
  `ARPC_NEVER(a_cache_grow, |($past(cache_valid_q) & ~cache_valid_q), "cache valid bit cleared")

endmodule
